[sv/nd_index_walker_unit_assert.svh]
// Assertion macros of the nd index walker RTL.
// Needs clk and arst_n in the scope of the module that uses them.
`ifndef ND_INDEX_WALKER_UNIT_ASSERT_SVH
`define ND_INDEX_WALKER_UNIT_ASSERT_SVH

// Check a condition in the cycle after a trigger
`define NDIW_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

// Check a condition in the same cycle as a trigger
`define NDIW_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

[sv/ndiw_pkg.sv]
// Shared constants, codes and types of the nd index walker.
// No dependencies; used by every module of the block.
package ndiw_pkg;

	// Fixed field widths
	localparam int POS_BITS       = 48;
	localparam int SIZE_BITS      = 13;
	localparam int DIMC_BITS      = 3;
	localparam int NUM_SIZE_REGS  = 4;
	localparam int NUM_OUT_COORDS = 4;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 13;

	// Defaults of the top level parameters
	localparam int DEF_MAX_DIMS   = 4;
	localparam int DEF_COORD_BITS = 12;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_DIM_COUNT = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_0    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_3    = 3'd4;

	// Request commands
	localparam logic CMD_SEEK    = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	// Cell operations
	localparam logic [1:0] CELL_HOLD  = 2'd0;
	localparam logic [1:0] CELL_CLEAR = 2'd1;
	localparam logic [1:0] CELL_SHIFT = 2'd2;
	localparam logic [1:0] CELL_STEP  = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic       end_hit;
	} cell_ctrl_t;

	typedef struct packed {
		logic carry;
		logic in_range;
		logic border;
	} cell_stat_t;

	// Quotient bit stream between neighbouring cells
	typedef struct packed {
		logic vld;
		logic qbit;
	} link_t;

endpackage

[sv/ndiw_cell.sv]
// One dimension of the walker: holds its coordinate, divides a bit stream by
// its extent during a seek and steps like an odometer digit. Uses ndiw_pkg.
module ndiw_cell #(
	parameter int COORD_BITS = ndiw_pkg::DEF_COORD_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ndiw_pkg::cell_ctrl_t   ctrl,
	input  logic                   used,
	input  logic [COORD_BITS:0]    ext,
	input  ndiw_pkg::link_t        link_in,
	input  logic                   carry_in,
	output ndiw_pkg::link_t        link_out,
	output ndiw_pkg::cell_stat_t   stat,
	output logic [COORD_BITS-1:0]  coord_nxt
);
	import ndiw_pkg::*;

	logic [COORD_BITS-1:0] coord_q;
	logic [COORD_BITS:0]   coord_inc;
	logic [COORD_BITS:0]   nxt_inc;
	logic [COORD_BITS:0]   rem_t;
	logic [COORD_BITS:0]   rem_sub;
	logic                  at_max;
	logic                  rem_ge;
	link_t                 link_q;

	// One restoring division step and the odometer compare
	always_comb begin
		coord_inc = {1'b0, coord_q} + (COORD_BITS+1)'(1);
		at_max    = coord_inc >= ext;
		rem_t     = {coord_q, link_in.qbit};
		rem_ge    = rem_t >= ext;
		rem_sub   = rem_t - ext;
	end

	// Select the next coordinate
	always_comb begin
		case (ctrl.op)
			CELL_CLEAR: coord_nxt = '0;
			CELL_SHIFT: begin
				if (!link_in.vld)
					coord_nxt = coord_q;
				else if (rem_ge)
					coord_nxt = rem_sub[COORD_BITS-1:0];
				else
					coord_nxt = rem_t[COORD_BITS-1:0];
			end
			CELL_STEP: begin
				if (!used)
					coord_nxt = '0;
				else if (ctrl.end_hit || !carry_in)
					coord_nxt = coord_q;
				else if (at_max)
					coord_nxt = '0;
				else
					coord_nxt = coord_inc[COORD_BITS-1:0];
			end
			default: coord_nxt = coord_q;
		endcase
	end

	// Report carry, range and border
	always_comb begin
		nxt_inc        = {1'b0, coord_nxt} + (COORD_BITS+1)'(1);
		stat.carry     = carry_in & at_max;
		stat.in_range  = !used || (coord_inc <= ext);
		stat.border    = used && ((coord_nxt == '0) || (nxt_inc == ext));
	end

	// Hold the coordinate and pass the quotient bit on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_q <= '0;
			link_q  <= '0;
		end else begin
			coord_q <= coord_nxt;
			if (ctrl.op == CELL_SHIFT) begin
				link_q.vld  <= link_in.vld;
				link_q.qbit <= rem_ge;
			end else begin
				link_q <= '0;
			end
		end
	end

	assign link_out = link_q;

endmodule

[sv/ndiw_pos_unit.sv]
// Iterative linear position rebuild: Horner over the used dimensions with a
// shift-add multiply, one extent bit per cycle. Uses ndiw_pkg.
module ndiw_pos_unit #(
	parameter int MAX_DIMS   = ndiw_pkg::DEF_MAX_DIMS,
	parameter int COORD_BITS = ndiw_pkg::DEF_COORD_BITS,
	localparam int DIM_IW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [DIM_IW-1:0]             top_dim,
	input  logic [COORD_BITS-1:0]         coords [MAX_DIMS],
	input  logic [COORD_BITS:0]           exts [MAX_DIMS],
	output logic                          busy,
	output logic [ndiw_pkg::POS_BITS-1:0] pos
);
	import ndiw_pkg::*;

	localparam int BIT_IW = $clog2(COORD_BITS + 1);

	logic                  busy_q;
	logic                  mul_phase_q;
	logic [DIM_IW-1:0]     q_q;
	logic [BIT_IW-1:0]     bit_q;
	logic [POS_BITS-1:0]   acc_q;
	logic [POS_BITS-1:0]   mul_q;
	logic [COORD_BITS:0]   ext_sel;
	logic [COORD_BITS-1:0] coord_sel;

	// Read the dimension being folded in
	always_comb begin
		ext_sel   = exts[q_q];
		coord_sel = coords[q_q];
	end

	// Sequence add and multiply phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			mul_phase_q <= 1'b0;
			q_q         <= '0;
			bit_q       <= '0;
		end else if (start) begin
			busy_q      <= 1'b1;
			mul_phase_q <= 1'b0;
			q_q         <= top_dim;
		end else if (busy_q) begin
			if (!mul_phase_q) begin
				if (q_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					q_q         <= q_q - DIM_IW'(1);
					mul_phase_q <= 1'b1;
					bit_q       <= BIT_IW'(COORD_BITS);
				end
			end else begin
				if (bit_q == '0)
					mul_phase_q <= 1'b0;
				else
					bit_q <= bit_q - BIT_IW'(1);
			end
		end
	end

	// Accumulate the position
	always_ff @(posedge clk) begin
		if (start) begin
			mul_q <= '0;
		end else if (busy_q) begin
			if (!mul_phase_q) begin
				acc_q <= mul_q + POS_BITS'(coord_sel);
				mul_q <= '0;
			end else begin
				mul_q <= {mul_q[POS_BITS-2:0], 1'b0} + (ext_sel[bit_q] ? acc_q : '0);
			end
		end
	end

	assign busy = busy_q;
	assign pos  = acc_q;

endmodule

[sv/nd_index_walker_unit.sv]
// Top level of the nd index walker: configuration, control and result register.
// Depends on ndiw_pkg, ndiw_cell, ndiw_pos_unit and the assertion macro header.
// Advance with a consistent position: one request per cycle while the result is taken,
// result registered in the next cycle. Seek: a bit-serial division chain, then
// the shift-add position rebuild.
// Advance after a register write: position rebuild before the result. Reset: coordinates
// and position zero, one dimension of extent one, no result pending.
`include "nd_index_walker_unit_assert.svh"

module nd_index_walker_unit #(
	parameter int MAX_DIMS   = ndiw_pkg::DEF_MAX_DIMS,
	parameter int COORD_BITS = ndiw_pkg::DEF_COORD_BITS,
	localparam int OUT_W     =
		((ndiw_pkg::NUM_OUT_COORDS * COORD_BITS + ndiw_pkg::POS_BITS + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ndiw_pkg::POS_BITS-1:0]      s_tdata,   // seek_index
	input  logic [0:0]                         s_tuser,   // command
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [OUT_W-1:0]                   m_tdata,   // coord_0..coord_3, linear_pos
	output logic [1:0]                         m_tuser,   // at_end, on_border
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ndiw_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [ndiw_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import ndiw_pkg::*;

	localparam int DIM_IW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DCNT_W    = $clog2(MAX_DIMS + 1);
	localparam int SEEK_LAST = POS_BITS + MAX_DIMS - 2;
	localparam int CNT_W     = $clog2(SEEK_LAST + 1);
	localparam int CMP_W     = (SIZE_BITS > COORD_BITS + 1) ? SIZE_BITS : COORD_BITS + 1;
	localparam int SIDX_W    = $clog2(NUM_SIZE_REGS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEEK = 2'd1;
	localparam logic [1:0] ST_POS  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [DIMC_BITS-1:0]  dim_count_q;
	logic [SIZE_BITS-1:0]  size_q [NUM_SIZE_REGS];
	logic [1:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [POS_BITS-1:0]   seek_q;
	logic                  end_q;
	logic                  clean_q;
	logic [POS_BITS-1:0]   pos_q;
	logic                  out_vld_q;
	logic [OUT_W-1:0]      out_data_q;
	logic [1:0]            out_user_q;

	logic [DCNT_W-1:0]     dims;
	logic [DIM_IW-1:0]     top_dim;
	logic                  used_a [MAX_DIMS];
	logic [COORD_BITS:0]   ext_a [MAX_DIMS];
	logic [COORD_BITS-1:0] coord_nxt_a [MAX_DIMS];
	logic [COORD_BITS-1:0] coord_out [NUM_OUT_COORDS];
	cell_stat_t            stat_a [MAX_DIMS];
	link_t                 link_a [MAX_DIMS+1];
	logic                  carry_a [MAX_DIMS+1];
	cell_ctrl_t            cell_ctrl;

	logic                  out_free;
	logic                  acc;
	logic                  is_adv;
	logic                  all_in;
	logic                  any_border;
	logic                  fast;
	logic                  end_all;
	logic                  pos_start;
	logic                  pos_busy;
	logic [POS_BITS-1:0]   pos_res;
	logic [POS_BITS-1:0]   pos_nxt;
	logic                  capture;
	logic [OUT_W-1:0]      out_data_nxt;
	logic [SIDX_W-1:0]     size_idx;

	// Clamp the dimension count
	always_comb begin
		if (dim_count_q == '0)
			dims = DCNT_W'(1);
		else if (int'(dim_count_q) > MAX_DIMS)
			dims = DCNT_W'(MAX_DIMS);
		else
			dims = DCNT_W'(dim_count_q);
		top_dim = DIM_IW'(dims - DCNT_W'(1));
	end

	// Effective extent of each dimension: one for unused ones or a zero size, capped at 2**COORD_BITS
	for (genvar q = 0; q < MAX_DIMS; q++) begin : g_ext
		assign used_a[q] = int'(dims) > q;
		if (q < NUM_SIZE_REGS) begin : g_reg
			logic [CMP_W-1:0] sz_w;
			logic [CMP_W-1:0] lim;
			always_comb begin
				sz_w = CMP_W'(size_q[q]);
				lim  = CMP_W'(1) << COORD_BITS;
				if (!used_a[q] || size_q[q] == '0)
					ext_a[q] = (COORD_BITS+1)'(1);
				else if (sz_w > lim)
					ext_a[q] = (COORD_BITS+1)'(lim);
				else
					ext_a[q] = (COORD_BITS+1)'(sz_w);
			end
		end else begin : g_fixed
			assign ext_a[q] = (COORD_BITS+1)'(1);
		end
	end

	// Handshake and command decode
	always_comb begin
		out_free = !out_vld_q || m_tready;
		s_tready = (state_q == ST_IDLE) && out_free;
		acc      = s_tvalid && s_tready;
		is_adv   = s_tuser[0] == CMD_ADVANCE;
		all_in   = 1'b1;
		any_border = 1'b0;
		for (int q = 0; q < MAX_DIMS; q++) begin
			all_in     = all_in && stat_a[q].in_range;
			any_border = any_border || stat_a[q].border;
		end
		end_all   = carry_a[MAX_DIMS];
		fast      = is_adv && clean_q && all_in;
		pos_start = (acc && is_adv && !fast)
			|| (state_q == ST_SEEK && cnt_q == CNT_W'(SEEK_LAST));
		capture   = (acc && fast) || (state_q == ST_DONE && out_free);
	end

	// Drive the cell row
	always_comb begin
		if (acc)
			cell_ctrl.op = is_adv ? CELL_STEP : CELL_CLEAR;
		else if (state_q == ST_SEEK)
			cell_ctrl.op = CELL_SHIFT;
		else
			cell_ctrl.op = CELL_HOLD;
		cell_ctrl.end_hit = end_all;
		link_a[0].vld     = (state_q == ST_SEEK) && (int'(cnt_q) < POS_BITS);
		link_a[0].qbit    = seek_q[POS_BITS-1];
		carry_a[0]        = 1'b1;
	end

	for (genvar q = 0; q < MAX_DIMS; q++) begin : g_cell
		ndiw_cell #(
			.COORD_BITS(COORD_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.used     (used_a[q]),
			.ext      (ext_a[q]),
			.link_in  (link_a[q]),
			.carry_in (carry_a[q]),
			.link_out (link_a[q+1]),
			.stat     (stat_a[q]),
			.coord_nxt(coord_nxt_a[q])
		);
		assign carry_a[q+1] = stat_a[q].carry;
	end

	ndiw_pos_unit #(
		.MAX_DIMS  (MAX_DIMS),
		.COORD_BITS(COORD_BITS)
	) u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pos_start),
		.top_dim(top_dim),
		.coords (coord_nxt_a),
		.exts   (ext_a),
		.busy   (pos_busy),
		.pos    (pos_res)
	);

	// Next linear position
	always_comb begin
		if (acc && fast && !end_all)
			pos_nxt = pos_q + POS_BITS'(1);
		else if (state_q == ST_POS && !pos_busy)
			pos_nxt = pos_res;
		else
			pos_nxt = pos_q;
	end

	// Coordinates beyond the row read as zero
	for (genvar k = 0; k < NUM_OUT_COORDS; k++) begin : g_out
		if (k < MAX_DIMS) begin : g_live
			assign coord_out[k] = coord_nxt_a[k];
		end else begin : g_zero
			assign coord_out[k] = '0;
		end
	end

	// Pack the result
	always_comb begin
		out_data_nxt = '0;
		for (int k = 0; k < NUM_OUT_COORDS; k++)
			out_data_nxt[k*COORD_BITS +: COORD_BITS] = coord_out[k];
		out_data_nxt[NUM_OUT_COORDS*COORD_BITS +: POS_BITS] = pos_nxt;
	end

	assign size_idx = SIDX_W'(cfg_index - REG_SIZE_0);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= DIMC_BITS'(1);
			for (int q = 0; q < NUM_SIZE_REGS; q++)
				size_q[q] <= SIZE_BITS'(1);
		end else if (cfg_valid) begin
			if (cfg_index == REG_DIM_COUNT)
				dim_count_q <= cfg_data[DIMC_BITS-1:0];
			else if (cfg_index inside {[REG_SIZE_0:REG_SIZE_3]})
				size_q[size_idx] <= cfg_data[SIZE_BITS-1:0];
		end
	end

	// Sequence requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			end_q   <= 1'b0;
			pos_q   <= '0;
		end else begin
			pos_q <= pos_nxt;
			case (state_q)
				ST_IDLE: begin
					if (acc && !is_adv) begin
						state_q <= ST_SEEK;
						cnt_q   <= '0;
						end_q   <= 1'b0;
					end else if (acc && !fast) begin
						state_q <= ST_POS;
						end_q   <= end_all;
					end
				end
				ST_SEEK: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SEEK_LAST))
						state_q <= ST_POS;
				end
				ST_POS: begin
					if (!pos_busy)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Drop the position shortcut on a register write, restore it after a rebuild
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clean_q <= 1'b1;
		else if (cfg_valid && cfg_ready)
			clean_q <= 1'b0;
		else if (state_q == ST_POS && !pos_busy)
			clean_q <= 1'b1;
	end

	// Shift the seek index out, top bit first
	always_ff @(posedge clk) begin
		if (acc && !is_adv)
			seek_q <= s_tdata;
		else if (state_q == ST_SEEK)
			seek_q <= {seek_q[POS_BITS-2:0], 1'b0};
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (capture)
			out_vld_q <= 1'b1;
		else if (m_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			out_data_q    <= out_data_nxt;
			out_user_q[0] <= (state_q == ST_DONE) ? end_q : end_all;
			out_user_q[1] <= any_border;
		end
	end

	assign m_tvalid  = out_vld_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_user_q;
	assign cfg_ready = 1'b1;

	`NDIW_ASSERT_NEXT(a_fast_step, acc && fast && !end_all, pos_q == $past(pos_q) + 1'b1, "fast advance did not step the position")
	`NDIW_ASSERT_NEXT(a_seek_len, state_q == ST_SEEK && cnt_q == CNT_W'(SEEK_LAST), state_q == ST_POS && pos_busy, "seek chain did not hand over to the position rebuild")
	`NDIW_ASSERT_SAME(a_pos_owner, pos_busy, state_q == ST_POS, "position unit busy outside its state")
	`NDIW_ASSERT_NEXT(a_seek_no_end, acc && !is_adv, !end_q && state_q == ST_SEEK, "seek request left the end flag set")

endmodule
